// ===== hdl/psq_pkg.sv =====
package psq_pkg;

    localparam int unsigned HANDLE_W = 8;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [HANDLE_W-1:0] proc_handle;
        logic [PRIO_W-1:0]   proc_prio;
    } t_entry;

endpackage

// ===== hdl/psq_ram.sv =====
module psq_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/priority_select_queue.sv =====
// Channel   Direction  Handshake                      Payload
// command   in         i_start && !o_busy             i_cmd, i_proc_handle, i_proc_priority
// result    out        o_result_valid (one cycle)     o_status, o_out_handle, o_out_priority,
//                                                     o_count
// config    in         i_cfg_valid && o_cfg_ready     i_cfg_data (fifo_mode)
//
// Enqueue, dequeue on an empty queue and enqueue on a full queue are each served without
// leaving idle and can follow one another back to back; the result appears the cycle after the beat.
// A successful dequeue walks the entries through the single read port of the entry RAM:
// a scan with one priority comparator (only the head entry is read in fifo mode), then a
// gap-closing copy that moves each later entry one place lower, with o_busy held high.
// Reset is synchronous and needs no clearing pass.
// The receiver cannot stall; each result is valid for exactly one cycle.
module priority_select_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_cmd,
    input  logic [psq_pkg::HANDLE_W-1:0]    i_proc_handle,
    input  logic [psq_pkg::PRIO_W-1:0]      i_proc_priority,
    output logic                            o_result_valid,
    output logic [psq_pkg::STATUS_W-1:0]    o_status,
    output logic [psq_pkg::HANDLE_W-1:0]    o_out_handle,
    output logic [psq_pkg::PRIO_W-1:0]      o_out_priority,
    output logic [psq_pkg::COUNT_W-1:0]     o_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]                         r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic                               r_fifo;
    logic [CW-1:0]                      r_ptr, n_ptr;
    logic [CW-1:0]                      r_last, n_last;
    logic                               r_pend, n_pend;
    logic [CW-1:0]                      r_pidx, n_pidx;
    psq_pkg::t_entry                    r_best, n_best;
    logic [CW-1:0]                      r_best_idx, n_best_idx;
    logic                               r_res_valid, n_res_valid;
    logic [psq_pkg::STATUS_W-1:0]       r_status, n_status;
    logic [psq_pkg::HANDLE_W-1:0]       r_res_handle, n_res_handle;
    logic [psq_pkg::PRIO_W-1:0]         r_res_prio, n_res_prio;
    logic [CW-1:0]                      r_res_count, n_res_count;

    logic                               w_we;
    logic [AW-1:0]                      w_waddr;
    psq_pkg::t_entry                    w_wdata;
    logic [AW-1:0]                      w_raddr;
    psq_pkg::t_entry                    w_rdata;
    logic                               w_better;
    logic                               w_issue;
    logic [CW-1:0]                      w_pidx_m1;
    logic [31:0]                        w_count_ext;

    psq_ram #(
        .WIDTH ($bits(psq_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Strictly smaller wins, so the earliest entry is kept on equal priorities.
    assign w_better  = (r_pidx == '0) || (w_rdata.proc_prio < r_best.proc_prio);
    assign w_pidx_m1 = r_pidx - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_last       = r_last;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_res_valid  = 1'b0;
        n_status     = r_status;
        n_res_handle = r_res_handle;
        n_res_prio   = r_res_prio;
        n_res_count  = r_res_count;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_raddr      = r_ptr[AW-1:0];
        w_issue      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == psq_pkg::CMD_ENQ) begin
                        n_res_valid  = 1'b1;
                        n_res_handle = '0;
                        n_res_prio   = '0;
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = psq_pkg::STATUS_FULL;
                        end else begin
                            w_we                = 1'b1;
                            w_waddr             = r_count[AW-1:0];
                            w_wdata.proc_handle = i_proc_handle;
                            w_wdata.proc_prio   = i_proc_priority;
                            n_count             = r_count + CW'(1);
                            n_status            = psq_pkg::STATUS_OK;
                        end
                        n_res_count = n_count;
                    end else if (r_count == '0) begin
                        n_res_valid  = 1'b1;
                        n_status     = psq_pkg::STATUS_EMPTY;
                        n_res_handle = '0;
                        n_res_prio   = '0;
                        n_res_count  = r_count;
                    end else begin
                        n_state = S_SCAN;
                        n_ptr   = '0;
                        n_pend  = 1'b0;
                        n_last  = r_fifo ? '0 : (r_count - CW'(1));
                    end
                end
            end
            S_SCAN: begin
                // Reads are issued one per cycle; the data of each read is compared in the cycle after it is issued.
                w_issue = (r_ptr <= r_last);
                if (w_issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                n_pend = w_issue;
                n_pidx = r_ptr;
                if (r_pend && w_better) begin
                    n_best     = w_rdata;
                    n_best_idx = r_pidx;
                end
                if (!w_issue && r_pend) begin
                    n_state = S_SHIFT;
                    n_ptr   = n_best_idx + CW'(1);
                end
            end
            S_SHIFT: begin
                // Each later entry is read and written back one place lower.
                w_issue = (r_ptr < r_count);
                if (w_issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                n_pend = w_issue;
                n_pidx = r_ptr;
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = w_pidx_m1[AW-1:0];
                    w_wdata = w_rdata;
                end
                if (!w_issue && !r_pend) begin
                    n_state      = S_IDLE;
                    n_count      = r_count - CW'(1);
                    n_res_valid  = 1'b1;
                    n_status     = psq_pkg::STATUS_OK;
                    n_res_handle = r_best.proc_handle;
                    n_res_prio   = r_best.proc_prio;
                    n_res_count  = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fifo      <= 1'b0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                r_fifo <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_last       <= n_last;
        r_pidx       <= n_pidx;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_status     <= n_status;
        r_res_handle <= n_res_handle;
        r_res_prio   <= n_res_prio;
        r_res_count  <= n_res_count;
    end

    // The count port shows the held count modulo 32.
    assign w_count_ext = 32'(r_res_count);

    assign o_busy              = (r_state != S_IDLE);
    assign o_result_valid      = r_res_valid;
    assign o_status            = r_status;
    assign o_out_handle        = r_res_handle;
    assign o_out_priority      = r_res_prio;
    assign o_count             = w_count_ext[psq_pkg::COUNT_W-1:0];
    assign o_cfg_ready         = 1'b1;

endmodule

// ===== sim/priority_select_queue_checker.sv =====
`timescale 1ns / 100ps

module priority_select_queue_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_cmd,
    input  logic [psq_pkg::HANDLE_W-1:0]    i_proc_handle,
    input  logic [psq_pkg::PRIO_W-1:0]      i_proc_priority,
    input  logic                            i_result_valid,
    input  logic [psq_pkg::STATUS_W-1:0]    i_status,
    input  logic [psq_pkg::HANDLE_W-1:0]    i_out_handle,
    input  logic [psq_pkg::PRIO_W-1:0]      i_out_priority,
    input  logic [psq_pkg::COUNT_W-1:0]     i_count,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic                            i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_full_seen,
    output int                              o_empty_seen
);

    typedef struct packed {
        logic [psq_pkg::STATUS_W-1:0] status;
        logic [psq_pkg::HANDLE_W-1:0] proc_handle;
        logic [psq_pkg::PRIO_W-1:0]   proc_prio;
        logic [psq_pkg::COUNT_W-1:0]  held;
    } t_outcome;

    psq_pkg::t_entry ready_list [QUEUE_DEPTH];
    int              held_count;
    logic            fifo_mode;
    t_outcome        pending_results [$];
    int              errors;
    int              checked;
    int              full_seen;
    int              empty_seen;

    initial begin
        held_count = 0;
        fifo_mode  = 1'b0;
        errors     = 0;
        checked    = 0;
        full_seen  = 0;
        empty_seen = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Updates the scheduler's ready list for one command and returns its result.
    function automatic t_outcome serve_command(input logic cmd,
                                               input logic [psq_pkg::HANDLE_W-1:0] handle,
                                               input logic [psq_pkg::PRIO_W-1:0] prio);
        t_outcome res;
        int       sel;

        res = '0;
        if (cmd == psq_pkg::CMD_ENQ) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = psq_pkg::STATUS_FULL;
            end else begin
                ready_list[held_count].proc_handle = handle;
                ready_list[held_count].proc_prio   = prio;
                held_count++;
                res.status = psq_pkg::STATUS_OK;
            end
        end else if (held_count == 0) begin
            res.status = psq_pkg::STATUS_EMPTY;
        end else begin
            sel = 0;
            if (!fifo_mode) begin
                // Strict less-than keeps the oldest entry among equal priorities.
                for (int i = 1; i < held_count; i++) begin
                    if (ready_list[i].proc_prio < ready_list[sel].proc_prio) begin
                        sel = i;
                    end
                end
            end
            res.status      = psq_pkg::STATUS_OK;
            res.proc_handle = ready_list[sel].proc_handle;
            res.proc_prio   = ready_list[sel].proc_prio;
            for (int i = sel; i + 1 < held_count; i++) begin
                ready_list[i] = ready_list[i + 1];
            end
            held_count--;
        end
        res.held = held_count[psq_pkg::COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;

        if (!i_rst_n) begin
            held_count = 0;
            fifo_mode  = 1'b0;
            pending_results.delete();
        end else begin
            if (i_result_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("commands outstanding at a result beat", 0, 1);
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (i_status != want.status) begin
                        report_mismatch("status", int'(i_status), int'(want.status));
                    end
                    if (i_out_handle != want.proc_handle) begin
                        report_mismatch("out_handle", int'(i_out_handle),
                                        int'(want.proc_handle));
                    end
                    if (i_out_priority != want.proc_prio) begin
                        report_mismatch("out_priority", int'(i_out_priority),
                                        int'(want.proc_prio));
                    end
                    if (i_count != want.held) begin
                        report_mismatch("count", int'(i_count), int'(want.held));
                    end
                end
            end
            if (i_start && !i_busy) begin
                want = serve_command(i_cmd, i_proc_handle, i_proc_priority);
                if (want.status == psq_pkg::STATUS_FULL) begin
                    full_seen++;
                end
                if (want.status == psq_pkg::STATUS_EMPTY) begin
                    empty_seen++;
                end
                pending_results.push_back(want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                fifo_mode = i_cfg_data;
            end
        end
        o_errors     <= errors;
        o_pending    <= pending_results.size();
        o_checked    <= checked;
        o_full_seen  <= full_seen;
        o_empty_seen <= empty_seen;
    end

endmodule

// ===== sim/priority_select_queue_tb.sv =====
`timescale 1ns / 100ps

module priority_select_queue_tb;

    typedef logic [psq_pkg::HANDLE_W-1:0] t_handle;
    typedef logic [psq_pkg::PRIO_W-1:0]   t_prio;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_start         = 1'b0;
    logic                           i_cmd           = psq_pkg::CMD_ENQ;
    t_handle                        i_proc_handle   = '0;
    t_prio                          i_proc_priority = '0;
    logic                           i_cfg_valid     = 1'b0;
    logic                           i_cfg_data      = 1'b0;
    logic                           o_busy;
    logic                           o_result_valid;
    logic [psq_pkg::STATUS_W-1:0]   o_status;
    t_handle                        o_out_handle;
    t_prio                          o_out_priority;
    logic [psq_pkg::COUNT_W-1:0]    o_count;
    logic                           o_cfg_ready;

    int  errors;
    int  pending;
    int  checked;
    int  full_seen;
    int  empty_seen;
    int  commands_sent = 0;
    bit  quiet = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    priority_select_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_cmd               (i_cmd),
        .i_proc_handle       (i_proc_handle),
        .i_proc_priority     (i_proc_priority),
        .o_result_valid      (o_result_valid),
        .o_status            (o_status),
        .o_out_handle        (o_out_handle),
        .o_out_priority      (o_out_priority),
        .o_count             (o_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    priority_select_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_proc_handle   (i_proc_handle),
        .i_proc_priority (i_proc_priority),
        .i_result_valid  (o_result_valid),
        .i_status        (o_status),
        .i_out_handle    (o_out_handle),
        .i_out_priority  (o_out_priority),
        .i_count         (o_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_seen     (full_seen),
        .o_empty_seen    (empty_seen)
    );

    // Holds one command on the port until the block takes the beat.
    task automatic send_command(input logic cmd, input t_handle handle, input t_prio prio);
        i_start         <= 1'b1;
        i_cmd           <= cmd;
        i_proc_handle   <= handle;
        i_proc_priority <= prio;
        do @(posedge i_clk); while (o_busy);
        commands_sent++;
        if (!quiet && $urandom_range(0, 99) < 15) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_busy);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Leans toward a few low values and the all-ones value so that equal priorities show up often.
    function automatic t_prio pick_priority();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return t_prio'($urandom_range(0, 2));
        end else if (roll < 40) begin
            return ($urandom_range(0, 1) != 0) ? {psq_pkg::PRIO_W{1'b1}} : t_prio'(0);
        end
        return t_prio'($urandom);
    endfunction

    // The enqueue share changes every few dozen commands so that the queue
    // swings between empty and full.
    task automatic run_random(input int n_items);
        int enq_share;

        enq_share = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k % 32 == 0) begin
                case ($urandom_range(0, 3))
                    0: enq_share = 25;
                    1: enq_share = 50;
                    2: enq_share = 75;
                    default: enq_share = 90;
                endcase
            end
            send_command(($urandom_range(0, 99) < enq_share) ? psq_pkg::CMD_ENQ
                                                             : psq_pkg::CMD_DEQ,
                         t_handle'($urandom), pick_priority());
        end
    endtask

    initial begin
        t_prio fill_prio [16];

        fill_prio = '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00,
                      8'h40, 8'h40, 8'hFF, 8'h10, 8'h01, 8'h55, 8'hAA, 8'h00};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, fill to the limit, one rejected enqueue,
        // then removals in priority order with ties on the lowest value.
        send_command(psq_pkg::CMD_DEQ, 8'hFF, 8'hFF);
        for (int k = 0; k < 16; k++) begin
            send_command(psq_pkg::CMD_ENQ,
                         (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : t_handle'(k * 17),
                         fill_prio[k]);
        end
        send_command(psq_pkg::CMD_ENQ, 8'hC3, 8'h00);
        repeat (5) send_command(psq_pkg::CMD_DEQ, 8'h00, 8'h00);

        write_mode(1'b1);
        run_random(300);
        write_mode(1'b0);
        run_random(300);
        write_mode(1'b1);
        run_random(150);
        write_mode(1'b0);
        quiet = 1'b1;
        run_random(150);
        wait_drained();

        $display("Sent %0d commands across both removal modes, %0d results checked.",
                 commands_sent, checked);
        $display("Saw %0d rejected enqueues on a full queue and %0d dequeues on an empty one.",
                 full_seen, empty_seen);
        if (errors == 0 && pending == 0) begin
            $display("PASS priority_select_queue");
        end else begin
            $display("FAIL priority_select_queue");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL priority_select_queue");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/psq_pkg.sv
hdl/psq_ram.sv
hdl/priority_select_queue.sv
sim/priority_select_queue_checker.sv
sim/priority_select_queue_tb.sv
